// ----- sv/mpc_pkg.sv -----
// ----------------------------------------------------------------------------
// mpc_pkg
// shared types and constants of the morse pulse classifier
// ----------------------------------------------------------------------------
`default_nettype none

package mpc_pkg;

	// symbol slots in the design and code fields on the result port
	localparam int MAX_SYMBOLS_DEF = 6;
	localparam int CODE_FIELDS     = 6;

	// configuration register widths and reset values
	localparam int DIT_W = 11;
	localparam int TOL_W = 12;
	localparam int CFG_DATA_W = 12;
	localparam int CFG_IDX_W = 2;
	localparam logic [DIT_W-1:0] DIT_RESET = 11'd80;
	localparam logic [TOL_W-1:0] TOL_RESET = 12'd80;
	localparam logic             GAP_EN_RESET = 1'b1;

	// input action codes
	typedef enum logic {
		ACT_PULSE  = 1'b0,
		ACT_FINISH = 1'b1
	} action_t;

	// symbol codes
	typedef enum logic [1:0] {
		SYM_NONE = 2'd0,
		SYM_DIT  = 2'd1,
		SYM_DAH  = 2'd3
	} sym_t;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DIT_TIME  = 2'd0,
		REG_WIDTH_TOL = 2'd1,
		REG_GAP_EN    = 2'd2
	} cfg_reg_t;

	// verdict on one pulse
	typedef struct packed {
		logic bad;
		sym_t code;
	} pulse_class_t;

endpackage

`default_nettype wire

// ----- sv/mpc_classify.sv -----
// ----------------------------------------------------------------------------
// mpc_classify
// gap check and dit/dah width match for one keying pulse
// ----------------------------------------------------------------------------
`default_nettype none

module mpc_classify
	import mpc_pkg::*;
(
	input  wire logic [DIT_W-1:0] dit_time,
	input  wire logic [TOL_W-1:0] width_tolerance,
	input  wire logic             gap_check,
	input  wire logic [31:0]      start_time,
	input  wire logic [31:0]      stop_time,
	input  wire logic [31:0]      prev_stop,
	output pulse_class_t          verdict
);

	// |w - nom| < tol, exact over 33 bits
	function automatic logic near(input logic [31:0] w, input logic [12:0] nom,
		input logic [TOL_W-1:0] tol);
		logic [32:0] d;
		logic [32:0] mag;
		begin
			d = {1'b0, w} - {20'b0, nom};
			mag = d[32] ? ({20'b0, nom} - {1'b0, w}) : d;
			return mag < {21'b0, tol};
		end
	endfunction

	logic [12:0] dah;
	logic [31:0] width;
	logic [31:0] gap;
	logic [9:0]  gap_lo;
	logic [11:0] gap_hi;
	logic        gap_bad;

	assign dah    = {2'b0, dit_time} + {1'b0, dit_time, 1'b0};
	assign width  = stop_time - start_time;
	assign gap    = start_time - prev_stop;
	assign gap_lo = dit_time[DIT_W-1:1];
	assign gap_hi = dah[12:1];
	assign gap_bad = gap_check && !(gap > {22'b0, gap_lo} && gap < {20'b0, gap_hi});

	always_comb begin
		verdict.bad  = 1'b0;
		verdict.code = SYM_NONE;
		if (gap_bad) begin
			verdict.bad = 1'b1;
		end else if (near(width, dah, width_tolerance)) begin
			verdict.code = SYM_DAH;
		end else if (near(width, {2'b0, dit_time}, width_tolerance)) begin
			verdict.code = SYM_DIT;
		end else begin
			verdict.bad = 1'b1;
		end
	end

endmodule

`default_nettype wire

// ----- sv/morse_pulse_classifier.sv -----
// ----------------------------------------------------------------------------
// morse_pulse_classifier
// classifies timed keying pulses as dit or dah and reports one character
// ----------------------------------------------------------------------------
// a finish request is held in the input register and then loads the result
//   register, which raises out_valid
// throughput: one request per cycle; in_stall rises only while a finish request
//   waits behind a result that the output side has not taken
// reset: arst_n clears the character state, the input and result valid flags and
//   restores dit_time 80, width_tolerance 80, gap_check_enable 1
`default_nettype none

module morse_pulse_classifier
	import mpc_pkg::*;
#(
	parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF
)(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// pulse / finish requests
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic                  action,
	input  wire logic [31:0]           start_time,
	input  wire logic [31:0]           stop_time,
	// character results
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic [1:0]                 code_0,
	output logic [1:0]                 code_1,
	output logic [1:0]                 code_2,
	output logic [1:0]                 code_3,
	output logic [1:0]                 code_4,
	output logic [1:0]                 code_5,
	output logic [2:0]                 pulse_count,
	output logic                       decode_ok,
	// register writes
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int CNT_W = $clog2(MAX_SYMBOLS + 1);

	// configuration registers
	logic [DIT_W-1:0] dit_q;
	logic [TOL_W-1:0] tol_q;
	logic             gap_en_q;

	// input register
	logic             valid_s1;
	action_t          action_s1;
	logic [31:0]      start_s1;
	logic [31:0]      stop_s1;

	// character state
	sym_t             sym_q [MAX_SYMBOLS];
	logic [CNT_W-1:0] cnt_q;
	logic             err_q;
	logic [31:0]      prev_stop_q;

	// result register
	logic             out_valid_q;
	sym_t             code_q [CODE_FIELDS];
	logic [2:0]       count_q;
	logic             ok_q;

	logic             in_take;
	logic             go_s1;
	logic             pulse_go;
	logic             finish_go;
	logic             slots_full;
	logic             err_next;
	logic [CNT_W+2:0] cnt_ext;
	logic [2:0]       count_sat;
	sym_t             code_next [CODE_FIELDS];
	pulse_class_t     verdict;

	// --------------------------------------------------------------------
	// register writes, taken every cycle
	// --------------------------------------------------------------------
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dit_q    <= DIT_RESET;
			tol_q    <= TOL_RESET;
			gap_en_q <= GAP_EN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_DIT_TIME:  dit_q    <= cfg_data[DIT_W-1:0];
				REG_WIDTH_TOL: tol_q    <= cfg_data[TOL_W-1:0];
				REG_GAP_EN:    gap_en_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// --------------------------------------------------------------------
	// input register: a pulse always moves on, a finish waits for the
	// result register to be free or drained in the same cycle
	// --------------------------------------------------------------------
	assign go_s1     = valid_s1 && (action_s1 == ACT_PULSE || !out_valid_q || !out_stall);
	assign pulse_go  = go_s1 && action_s1 == ACT_PULSE;
	assign finish_go = go_s1 && action_s1 == ACT_FINISH;
	assign in_stall  = valid_s1 && !go_s1;
	assign in_take   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (go_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			action_s1 <= action_t'(action);
			start_s1  <= start_time;
			stop_s1   <= stop_time;
		end
	end

	// --------------------------------------------------------------------
	// pulse verdict; the first pulse of a character skips the gap check
	// --------------------------------------------------------------------
	mpc_classify u_classify (
		.dit_time        (dit_q),
		.width_tolerance (tol_q),
		.gap_check       (gap_en_q && cnt_q != '0),
		.start_time      (start_s1),
		.stop_time       (stop_s1),
		.prev_stop       (prev_stop_q),
		.verdict         (verdict)
	);

	assign slots_full = cnt_q >= CNT_W'(MAX_SYMBOLS);
	// an extra pulse sets the error without a verdict of its own
	assign err_next   = err_q || slots_full || verdict.bad;

	// --------------------------------------------------------------------
	// character state: symbols freeze at the first error, a finish clears
	// --------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_SYMBOLS; i++) begin
				sym_q[i] <= SYM_NONE;
			end
			cnt_q       <= '0;
			err_q       <= 1'b0;
			prev_stop_q <= '0;
		end else if (finish_go) begin
			for (int i = 0; i < MAX_SYMBOLS; i++) begin
				sym_q[i] <= SYM_NONE;
			end
			cnt_q       <= '0;
			err_q       <= 1'b0;
			prev_stop_q <= '0;
		end else if (pulse_go) begin
			prev_stop_q <= stop_s1;
			err_q       <= err_next;
			if (!slots_full) begin
				cnt_q <= cnt_q + CNT_W'(1);
				for (int i = 0; i < MAX_SYMBOLS; i++) begin
					if (!err_next && cnt_q == CNT_W'(i)) begin
						sym_q[i] <= verdict.code;
					end
				end
			end
		end
	end

	// --------------------------------------------------------------------
	// result fields; slots beyond the symbol store read as none
	// --------------------------------------------------------------------
	for (genvar k = 0; k < CODE_FIELDS; k++) begin : g_code
		if (k < MAX_SYMBOLS) begin : g_slot
			assign code_next[k] = sym_q[k];
		end else begin : g_empty
			assign code_next[k] = SYM_NONE;
		end
	end

	// count saturates at the field's top value
	assign cnt_ext   = (CNT_W+3)'(cnt_q);
	assign count_sat = (cnt_ext > (CNT_W+3)'(7)) ? 3'd7 : cnt_ext[2:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish_go) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish_go) begin
			for (int k = 0; k < CODE_FIELDS; k++) begin
				code_q[k] <= code_next[k];
			end
			count_q <= count_sat;
			ok_q    <= !err_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign code_0      = code_q[0];
	assign code_1      = code_q[1];
	assign code_2      = code_q[2];
	assign code_3      = code_q[3];
	assign code_4      = code_q[4];
	assign code_5      = code_q[5];
	assign pulse_count = count_q;
	assign decode_ok   = ok_q;

	// --------------------------------------------------------------------
	// checks
	// --------------------------------------------------------------------
	// the pulse count never runs past the symbol store
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_SYMBOLS))
		else $error("pulse count beyond symbol store");

	// a finish leaves an empty character behind
	a_finish_clears: assert property (@(posedge clk) disable iff (!arst_n)
		finish_go |=> (cnt_q == '0 && !err_q && prev_stop_q == '0))
		else $error("character state not cleared after finish");

	// a new result only follows a finish request
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(finish_go))
		else $error("result raised without a finish request");

	// a pulse request is never held back
	a_pulse_flows: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && action_s1 == ACT_PULSE) |-> !in_stall)
		else $error("pulse request stalled");

endmodule

`default_nettype wire

// ----- sim/mpc_char_checker.sv -----
// ----------------------------------------------------------------------------
// mpc_char_checker
// watches the request, result and register channels of the classifier,
// predicts each character result and compares it field by field
// ----------------------------------------------------------------------------

module mpc_char_checker
	import mpc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_stall,
	input  logic                  action,
	input  logic [31:0]           start_time,
	input  logic [31:0]           stop_time,
	input  logic                  out_valid,
	input  logic                  out_stall,
	input  logic [1:0]            code_0,
	input  logic [1:0]            code_1,
	input  logic [1:0]            code_2,
	input  logic [1:0]            code_3,
	input  logic [1:0]            code_4,
	input  logic [1:0]            code_5,
	input  logic [2:0]            pulse_count,
	input  logic                  decode_ok,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    fail_count,
	output int                    outstanding,
	output int                    chars_checked
);

	typedef struct packed {
		logic [CODE_FIELDS-1:0][1:0] codes;
		logic [2:0]                  count;
		logic                        ok;
	} char_result_t;

	char_result_t expected_chars[$];

	// predicted character in progress
	sym_t             symbols[MAX_SYMBOLS_DEF];
	int               held;
	logic             err_seen;
	logic [31:0]      last_stop;

	// predicted register file
	logic [DIT_W-1:0] dit;
	logic [TOL_W-1:0] tol;
	logic             gap_en;

	int               checked;
	char_result_t     seen;

	function automatic logic near_nominal(logic [31:0] width, logic [31:0] nominal);
		logic [31:0] delta;
		delta = (width >= nominal) ? width - nominal : nominal - width;
		return delta < {20'b0, tol};
	endfunction

	task automatic clear_char();
		for (int k = 0; k < MAX_SYMBOLS_DEF; k++)
			symbols[k] = SYM_NONE;
		held = 0;
		err_seen = 1'b0;
		last_stop = '0;
	endtask

	task automatic absorb_pulse(logic [31:0] start, logic [31:0] stop);
		logic [31:0] width;
		logic [31:0] gap;
		logic [31:0] dit32;
		logic [31:0] dah;
		logic        bad;
		sym_t        code;
		width = stop - start;
		dit32 = {21'b0, dit};
		dah = 3 * dit32;
		bad = 1'b0;
		code = SYM_NONE;
		if (held >= MAX_SYMBOLS_DEF) begin
			// overflow pulse: flagged, not stored, not counted
			err_seen = 1'b1;
		end else begin
			if (gap_en && held > 0) begin
				gap = start - last_stop;
				if (!(gap > dit32 / 2 && gap < dah / 2))
					bad = 1'b1;
			end
			if (!bad) begin
				if (near_nominal(width, dah))
					code = SYM_DAH;
				else if (near_nominal(width, dit32))
					code = SYM_DIT;
				else
					bad = 1'b1;
			end
			if (bad)
				err_seen = 1'b1;
			if (!err_seen)
				symbols[held] = code;
			held++;
		end
		last_stop = stop;
	endtask

	task automatic close_char();
		char_result_t want;
		for (int k = 0; k < CODE_FIELDS; k++)
			want.codes[k] = (k < MAX_SYMBOLS_DEF) ? symbols[k] : SYM_NONE;
		want.count = (held > 7) ? 3'd7 : held[2:0];
		want.ok = !err_seen;
		expected_chars.push_back(want);
		clear_char();
	endtask

	task automatic flag_mismatch(string what, int got, int want);
		fail_count++;
		$display("mismatch at character %0d: %s is %0d, expected %0d",
			checked, what, got, want);
	endtask

	task automatic check_char(char_result_t got);
		char_result_t want;
		if (expected_chars.size() == 0) begin
			flag_mismatch("unexpected result, queue depth", 1, 0);
		end else begin
			want = expected_chars.pop_front();
			for (int k = 0; k < CODE_FIELDS; k++)
				if (got.codes[k] !== want.codes[k])
					flag_mismatch($sformatf("code_%0d", k), int'(got.codes[k]),
						int'(want.codes[k]));
			if (got.count !== want.count)
				flag_mismatch("pulse_count", int'(got.count), int'(want.count));
			if (got.ok !== want.ok)
				flag_mismatch("decode_ok", int'(got.ok), int'(want.ok));
		end
		checked++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_char();
			expected_chars.delete();
			dit = DIT_RESET;
			tol = TOL_RESET;
			gap_en = GAP_EN_RESET;
			checked = 0;
			fail_count = 0;
			outstanding <= 0;
			chars_checked <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_reg_t'(cfg_index))
					REG_DIT_TIME:  dit = cfg_data[DIT_W-1:0];
					REG_WIDTH_TOL: tol = cfg_data[TOL_W-1:0];
					REG_GAP_EN:    gap_en = cfg_data[0];
					default: ;
				endcase
			end
			// a result never belongs to the request taken at the same edge
			if (out_valid && !out_stall) begin
				seen.codes = {code_5, code_4, code_3, code_2, code_1, code_0};
				seen.count = pulse_count;
				seen.ok = decode_ok;
				check_char(seen);
			end
			if (in_valid && !in_stall) begin
				if (action_t'(action) == ACT_PULSE)
					absorb_pulse(start_time, stop_time);
				else
					close_char();
			end
			outstanding <= expected_chars.size();
			chars_checked <= checked;
		end
	end

endmodule

// ----- sim/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// top of the classifier testbench: clock, reset, keying stimulus, register
// settings and the verdict; prediction and comparison live in the checker
// ----------------------------------------------------------------------------

module tb;
	import mpc_pkg::*;

	localparam int CYCLE_LIMIT = 500000;
	// a finish result is registered at the same edge at which its request leaves
	// the input register; the settle wait covers any work still in flight
	localparam int SETTLE_CYCLES = 4;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic                  action = 1'b0;
	logic [31:0]           start_time = '0;
	logic [31:0]           stop_time = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [1:0]            code_0;
	logic [1:0]            code_1;
	logic [1:0]            code_2;
	logic [1:0]            code_3;
	logic [1:0]            code_4;
	logic [1:0]            code_5;
	logic [2:0]            pulse_count;
	logic                  decode_ok;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// from the checker
	int fail_count;
	int outstanding;
	int chars_checked;

	// stimulus bookkeeping
	int idle_pct = 0;
	int stall_pct = 0;
	int sent = 0;
	int settings = 0;
	int cycles = 0;
	int cur_dit = 80;
	int cur_tol = 80;

	morse_pulse_classifier dut (.*);

	mpc_char_checker u_checker (.*);

	always #10 clk = ~clk;

	// result side back-pressure
	always @(posedge clk)
		out_stall <= ($urandom_range(99) < stall_pct);

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout with %0d characters still expected", outstanding);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// one request, with a random idle gap in front of it
	task automatic push_request(action_t act, logic [31:0] start, logic [31:0] stop);
		int gap;
		gap = 0;
		while ($urandom_range(99) < idle_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		start_time <= start;
		stop_time <= stop;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sent++;
	endtask

	// wait until every predicted character has come out and the block is quiet
	task automatic drain();
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apply_setting(int dit, int tol, int gap_en);
		in_valid <= 1'b0;
		drain();
		write_reg(REG_DIT_TIME, dit[CFG_DATA_W-1:0]);
		write_reg(REG_WIDTH_TOL, tol[CFG_DATA_W-1:0]);
		write_reg(REG_GAP_EN, gap_en[CFG_DATA_W-1:0]);
		cur_dit = dit & 32'h7FF;
		cur_tol = tol & 32'hFFF;
		settings++;
	endtask

	// one keyed character of n pulses and its finish; noise_pct corrupts
	// widths and gaps, otherwise both sit inside the accepted windows, where the
	// register settings leave room for one, with extra weight on the edges
	task automatic key_character(int n, int noise_pct);
		logic [31:0] t;
		logic [31:0] start;
		logic [31:0] stop;
		logic [31:0] width;
		logic [31:0] gap;
		logic [31:0] nominal;
		int          lo;
		int          hi;
		int          mag;
		int          r;
		t = ($urandom_range(9) == 0) ? 32'hFFFF_FFFF - $urandom_range(5000) : $urandom;
		for (int p = 0; p < n; p++) begin
			lo = cur_dit / 2 + 1;
			hi = (3 * cur_dit) / 2 - 1;
			r = $urandom_range(9);
			if ($urandom_range(99) < noise_pct) begin
				case ($urandom_range(3))
					0: gap = lo - 1;
					1: gap = hi + 1;
					2: gap = $urandom;
					default: gap = $urandom_range(4 * cur_dit + 4);
				endcase
			end else if (hi >= lo) begin
				gap = (r == 0) ? lo : (r == 1) ? hi : $urandom_range(hi, lo);
			end else begin
				gap = $urandom_range(2);
			end
			start = (p == 0) ? t : t + gap;

			nominal = $urandom_range(1) ? 3 * cur_dit : cur_dit;
			mag = 0;
			if (cur_tol > 0)
				mag = ($urandom_range(9) == 0) ? cur_tol - 1 : $urandom_range(cur_tol - 1);
			width = $urandom_range(1) ? nominal + mag : nominal - mag;
			if ($urandom_range(99) < noise_pct) begin
				case ($urandom_range(2))
					0: width = nominal + cur_tol;
					1: width = $urandom;
					default: width = nominal + cur_tol + $urandom_range(3 * cur_dit + 100);
				endcase
			end
			stop = start + width;
			t = stop;
			push_request(ACT_PULSE, start, stop);
		end
		push_request(ACT_FINISH, $urandom, $urandom);
	endtask

	task automatic run_segment(int quota);
		int stop_at;
		int r;
		stop_at = sent + quota;
		while (sent < stop_at) begin
			r = $urandom_range(99);
			// mostly clean characters, some broken ones and some loose requests
			if (r < 65)
				key_character($urandom_range(6, 1), 0);
			else if (r < 85)
				key_character($urandom_range(8, 0), 30);
			else
				push_request(action_t'($urandom_range(1)), $urandom, $urandom);
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed characters at the reset register values:
		// dit 80, tolerance 80, gap window 40 < gap < 120

		// empty character
		push_request(ACT_FINISH, 32'h0000_0000, 32'h0000_0000);
		// dit then dah at nominal widths
		push_request(ACT_PULSE, 32'd0, 32'd80);
		push_request(ACT_PULSE, 32'd160, 32'd400);
		push_request(ACT_FINISH, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		// widths one inside tolerance, gap one above its lower bound
		push_request(ACT_PULSE, 32'd1000, 32'd1159);
		push_request(ACT_PULSE, 32'd1200, 32'd1361);
		push_request(ACT_FINISH, 32'd0, 32'hFFFF_FFFF);
		// widest width is an error, later pulse still counted
		push_request(ACT_PULSE, 32'd0, 32'hFFFF_FFFF);
		push_request(ACT_PULSE, 32'd39, 32'd119);
		push_request(ACT_FINISH, 32'hFFFF_FFFF, 32'd0);
		// gap just under the upper bound passes, gap at the bound freezes
		push_request(ACT_PULSE, 32'd1000, 32'd1080);
		push_request(ACT_PULSE, 32'd1199, 32'd1279);
		push_request(ACT_PULSE, 32'd1399, 32'd1479);
		push_request(ACT_FINISH, 32'd0, 32'd0);
		// seven pulses across the counter wrap: the seventh overflows
		for (int k = 0; k < 7; k++)
			push_request(ACT_PULSE, 32'hFFFF_FFF0 + k * 160, 32'hFFFF_FFF0 + k * 160 + 80);
		push_request(ACT_FINISH, 32'd0, 32'd0);

		// random part: one register setting per segment, idling mode rotating
		// through none, sender, receiver and both
		for (int seg = 0; seg < 9; seg++) begin
			case (seg)
				0: apply_setting(80, 80, 1);
				1: apply_setting(1, 0, 1);        // narrowest dit, no tolerance
				2: apply_setting(1200, 4095, 0);  // widest legal values, gaps unchecked
				3: apply_setting(1, 2, 0);
				4: apply_setting(100, 30, 1);
				5: apply_setting(1200, 400, 1);
				6: apply_setting(4095, 4095, 1);  // dit field all ones
				7: apply_setting(0, 10, 1);       // zero dit: no gap can pass
				default: apply_setting(80, 80, 1);
			endcase
			case (seg % 4)
				0: begin
					idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					idle_pct = 80;
					stall_pct = 0;
				end
				2: begin
					idle_pct = 0;
					stall_pct = 80;
				end
				default: begin
					idle_pct = 19;
					stall_pct = 19;
				end
			endcase
			run_segment(142);
		end

		in_valid <= 1'b0;
		drain();
		stall_pct = 0;

		$display("run covered %0d requests and %0d checked characters under %0d register settings",
			sent, chars_checked, settings);
		$display("idling phases: none, sender 80%%, receiver 80%%, both 19%%");
		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ----- files.f -----
sv/mpc_pkg.sv
sv/mpc_classify.sv
sv/morse_pulse_classifier.sv
sim/mpc_char_checker.sv
sim/tb.sv
